[hdl/ma_crossover_order_signal_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the crossover order signal block
// Immediate-consequence and next-cycle property forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MA_CROSSOVER_ORDER_SIGNAL_ASSERT_SVH
`define MA_CROSSOVER_ORDER_SIGNAL_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define MCOS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define MCOS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mcos_pkg.sv]
// ----------------------------------------------------------------------------
// mcos_pkg
// Types, codes and constants shared by the crossover order signal block.
// ----------------------------------------------------------------------------
package mcos_pkg;

	localparam int WINDOW_MAX_DEF  = 256;
	localparam int PRICE_SCALE_DEF = 100;

	localparam int TICK_W     = 32;
	localparam int MID_W      = 33;
	localparam int WIN_REG_W  = 9;
	localparam int SIZE_W     = 20;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;
	localparam int AVG_W      = 14;

	localparam logic [AVG_W-1:0] AVG_UNITS = 14'd10000;

	localparam logic CMD_WAKEUP = 1'b0;
	localparam logic CMD_QUOTE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_SIZE   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_SHORT  = 4'd3;

	localparam logic [WIN_REG_W-1:0] SHORT_WINDOW_RST = 9'd5;
	localparam logic [WIN_REG_W-1:0] LONG_WINDOW_RST  = 9'd20;
	localparam logic [SIZE_W-1:0]    ORDER_SIZE_RST   = 20'd100;

	localparam logic [2:0] ST_NONE        = 3'd0;
	localparam logic [2:0] ST_BUY         = 3'd1;
	localparam logic [2:0] ST_SELL        = 3'd2;
	localparam logic [2:0] ST_CASH_LIMIT  = 3'd3;
	localparam logic [2:0] ST_SHORT_LIMIT = 3'd4;
	localparam logic [2:0] ST_ORDERED     = 3'd5;
	localparam logic [2:0] ST_BAD_QUOTE   = 3'd6;

	typedef struct packed {
		logic                     cmd;
		logic [TICK_W-1:0]        bid_ticks;
		logic [TICK_W-1:0]        ask_ticks;
		logic signed [TICK_W-1:0] cash_now;
		logic signed [TICK_W-1:0] position_now;
	} mcos_in_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [TICK_W-1:0] order_price;
		logic [SIZE_W-1:0] order_volume;
	} mcos_out_t;

endpackage

[hdl/mcos_ring.sv]
// ----------------------------------------------------------------------------
// mcos_ring
// Ring of mid-price sums: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcos_ring #(
	parameter int DEPTH  = mcos_pkg::WINDOW_MAX_DEF,
	parameter int ADDR_W = $clog2(mcos_pkg::WINDOW_MAX_DEF),
	parameter int DATA_W = mcos_pkg::MID_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/mcos_div.sv]
// ----------------------------------------------------------------------------
// mcos_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mcos_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, acc_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign done  = busy_q && (cnt_q == '0);
	assign quot  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
			acc_q  <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				acc_q <= {acc_q[NUM_W-2:0], ge};
			end
		end
	end

endmodule

[hdl/ma_crossover_order_signal.sv]
// ----------------------------------------------------------------------------
// ma_crossover_order_signal
// Moving-average crossover order signal with running window sums in a ring.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A wakeup or a quote with a zero side goes straight
// to the S_OUT state, and a quote that stops before the crossover test passes
// through S_RD_S, S_RD_L and S_WR first; S_OUT loads the output register once
// that register is free. A quote that reaches the test also passes through the
// bit-serial divider, which forms first the short and then the long rounded
// average. The short and long sums are kept up to date with one ring read per
// window and one ring write per quote that has both sides nonzero. Register
// writes are taken only while the block is idle, ahead of an input beat offered
// in the same cycle. After a write to either window register the block rebuilds
// both sums from the ring, one entry per cycle, which holds the next input beat
// off until the rebuild is done.
// ----------------------------------------------------------------------------
module ma_crossover_order_signal #(
	parameter int WINDOW_MAX  = mcos_pkg::WINDOW_MAX_DEF,
	parameter int PRICE_SCALE = mcos_pkg::PRICE_SCALE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             evt_valid,
	output logic                             evt_ready,
	input  mcos_pkg::mcos_in_t               evt,
	output logic                             res_valid,
	input  logic                             res_ready,
	output mcos_pkg::mcos_out_t              res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mcos_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcos_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import mcos_pkg::*;

	localparam int PTR_W  = $clog2(WINDOW_MAX);
	localparam int WCNT_W = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = MID_W + PTR_W;
	localparam int PS_W   = $clog2(PRICE_SCALE + 1);
	localparam int BIAS_W = PS_W + WCNT_W;
	localparam int DEN_W  = BIAS_W + 1;
	localparam int PROD_W = SUM_W + AVG_W;
	localparam int NUM_W  = ((PROD_W > BIAS_W) ? PROD_W : BIAS_W) + 1;
	localparam int NEED_W = TICK_W + SIZE_W;
	localparam int CX_W   = TICK_W + PS_W;
	localparam int CMP_W  = (CX_W > NEED_W) ? CX_W : NEED_W;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_RD_S     = 4'd1;
	localparam logic [3:0] S_RD_L     = 4'd2;
	localparam logic [3:0] S_WR       = 4'd3;
	localparam logic [3:0] S_MUL      = 4'd4;
	localparam logic [3:0] S_DIV_GO   = 4'd5;
	localparam logic [3:0] S_DIV_WAIT = 4'd6;
	localparam logic [3:0] S_OUT      = 4'd7;
	localparam logic [3:0] S_SW_INIT  = 4'd8;
	localparam logic [3:0] S_SW_RUN   = 4'd9;

	function automatic logic [WCNT_W-1:0] clamp_win(input logic [WIN_REG_W-1:0] w);
		logic [WCNT_W-1:0] r;
		if (w == '0) begin
			r = WCNT_W'(1);
		end else if (32'(w) > 32'(WINDOW_MAX)) begin
			r = WCNT_W'(WINDOW_MAX);
		end else begin
			r = WCNT_W'(w);
		end
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] back_addr(input logic [PTR_W-1:0] p,
			input logic [WCNT_W-1:0] w);
		logic [WCNT_W:0] pe;
		logic [WCNT_W:0] we_ext;
		logic [PTR_W-1:0] r;
		pe     = (WCNT_W+1)'(p);
		we_ext = (WCNT_W+1)'(w);
		if (pe >= we_ext) begin
			r = PTR_W'(pe - we_ext);
		end else begin
			r = PTR_W'(pe + (WCNT_W+1)'(WINDOW_MAX) - we_ext);
		end
		return r;
	endfunction

	logic [WIN_REG_W-1:0] short_win_q;
	logic [WIN_REG_W-1:0] long_win_q;
	logic [SIZE_W-1:0]    order_size_q;
	logic                 allow_short_q;
	logic                 resync_q;

	logic [3:0]        state_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [WCNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]  ssum_q;
	logic [SUM_W-1:0]  lsum_q;
	logic              ordered_q;

	logic [TICK_W-1:0]        bid_q;
	logic [TICK_W-1:0]        ask_q;
	logic signed [TICK_W-1:0] cash_q;
	logic signed [TICK_W-1:0] pos_q;
	logic [MID_W-1:0]         mid_q;
	logic                     sub_s_q;
	logic                     sub_l_q;
	logic [NEED_W-1:0]        need_q;
	logic [CX_W-1:0]          cashx_q;
	logic [BIAS_W-1:0]        bias_s_q;
	logic [BIAS_W-1:0]        bias_l_q;
	logic                     buy_ref_q;
	logic                     sell_ref_q;
	logic [PROD_W-1:0]        prod_q;
	logic [NUM_W-1:0]         qs_q;
	logic                     which_q;
	mcos_out_t                pend_q;

	logic [PTR_W-1:0]  swp_addr_q;
	logic [WCNT_W-1:0] swp_k_q;
	logic [WCNT_W-1:0] swp_n_q;
	logic [WCNT_W-1:0] swp_ns_q;
	logic [WCNT_W-1:0] swp_nl_q;
	logic              swp_rv_s1;
	logic [WCNT_W-1:0] swp_k_s1;

	logic              res_valid_q;
	mcos_out_t         res_q;

	logic [WCNT_W-1:0] sw_eff;
	logic [WCNT_W-1:0] lw_eff;
	logic [WCNT_W-1:0] cnt_inc;
	logic [WCNT_W-1:0] ns_now;
	logic [WCNT_W-1:0] nl_now;
	logic [PTR_W-1:0]  ptr_inc;
	logic [PTR_W-1:0]  ptr_dec;
	logic [PTR_W-1:0]  swp_addr_dec;
	logic [TICK_W-1:0] cash_p1;
	logic [BIAS_W-1:0] bias_sel;
	logic              res_load;

	logic              ram_we;
	logic [PTR_W-1:0]  ram_raddr;
	logic [MID_W-1:0]  ram_rdata;

	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_done;
	logic [NUM_W-1:0]  div_quot;

	assign sw_eff       = clamp_win(short_win_q);
	assign lw_eff       = clamp_win(long_win_q);
	assign cnt_inc      = (cnt_q == WCNT_W'(WINDOW_MAX)) ? cnt_q : cnt_q + 1'b1;
	assign ns_now       = (sw_eff < cnt_q) ? sw_eff : cnt_q;
	assign nl_now       = (lw_eff < cnt_q) ? lw_eff : cnt_q;
	assign ptr_inc      = (ptr_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_q + 1'b1;
	assign ptr_dec      = (ptr_q == '0) ? PTR_W'(WINDOW_MAX - 1) : ptr_q - 1'b1;
	assign swp_addr_dec = (swp_addr_q == '0) ? PTR_W'(WINDOW_MAX - 1) : swp_addr_q - 1'b1;
	assign cash_p1      = unsigned'(cash_q) + 32'd1;
	assign bias_sel     = which_q ? bias_l_q : bias_s_q;

	assign evt_ready = (state_q == S_IDLE) && !resync_q && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign res_load  = (state_q == S_OUT) && (!res_valid_q || res_ready);

	assign ram_we    = (state_q == S_WR);
	assign div_start = (state_q == S_DIV_GO);
	assign div_num   = NUM_W'(prod_q) + NUM_W'(bias_sel);
	assign div_den   = {bias_sel, 1'b0};

	always_comb begin
		case (state_q)
			S_RD_S: ram_raddr = back_addr(ptr_q, sw_eff);
			S_RD_L: ram_raddr = back_addr(ptr_q, lw_eff);
			default: ram_raddr = swp_addr_q;
		endcase
	end

	mcos_ring #(
		.DEPTH  (WINDOW_MAX),
		.ADDR_W (PTR_W),
		.DATA_W (MID_W)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (mid_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mcos_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_win_q   <= SHORT_WINDOW_RST;
			long_win_q    <= LONG_WINDOW_RST;
			order_size_q  <= ORDER_SIZE_RST;
			allow_short_q <= 1'b0;
			resync_q      <= 1'b0;
		end else begin
			if (state_q == S_SW_INIT) begin
				resync_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SHORT_WINDOW: begin
						short_win_q <= cfg_data[WIN_REG_W-1:0];
						resync_q    <= 1'b1;
					end
					CFG_LONG_WINDOW: begin
						long_win_q <= cfg_data[WIN_REG_W-1:0];
						resync_q   <= 1'b1;
					end
					CFG_ORDER_SIZE: order_size_q <= cfg_data[SIZE_W-1:0];
					CFG_ALLOW_SHORT: allow_short_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ptr_q     <= '0;
			cnt_q     <= '0;
			ssum_q    <= '0;
			lsum_q    <= '0;
			ordered_q <= 1'b0;
			which_q   <= 1'b0;
			swp_rv_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (resync_q) begin
						state_q <= S_SW_INIT;
					end else if (evt_valid && evt_ready) begin
						bid_q   <= evt.bid_ticks;
						ask_q   <= evt.ask_ticks;
						cash_q  <= evt.cash_now;
						pos_q   <= evt.position_now;
						mid_q   <= MID_W'(evt.bid_ticks) + MID_W'(evt.ask_ticks);
						sub_s_q <= cnt_q >= sw_eff;
						sub_l_q <= cnt_q >= lw_eff;
						if (evt.cmd == CMD_WAKEUP) begin
							ordered_q <= 1'b0;
							pend_q    <= '{status: ST_NONE, order_price: '0, order_volume: '0};
							state_q   <= S_OUT;
						end else if (evt.bid_ticks == '0 || evt.ask_ticks == '0) begin
							pend_q  <= '{status: ST_BAD_QUOTE, order_price: '0,
								order_volume: '0};
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD_S;
						end
					end
				end
				S_RD_S: begin
					ssum_q  <= ssum_q + SUM_W'(mid_q);
					lsum_q  <= lsum_q + SUM_W'(mid_q);
					need_q  <= NEED_W'(ask_q) * NEED_W'(order_size_q);
					state_q <= S_RD_L;
				end
				S_RD_L: begin
					if (sub_s_q) begin
						ssum_q <= ssum_q - SUM_W'(ram_rdata);
					end
					cashx_q  <= CX_W'(cash_p1) * CX_W'(PRICE_SCALE);
					bias_s_q <= BIAS_W'(PRICE_SCALE) * BIAS_W'(sw_eff);
					state_q  <= S_WR;
				end
				S_WR: begin
					if (sub_l_q) begin
						lsum_q <= lsum_q - SUM_W'(ram_rdata);
					end
					bias_l_q   <= BIAS_W'(PRICE_SCALE) * BIAS_W'(lw_eff);
					ptr_q      <= ptr_inc;
					cnt_q      <= cnt_inc;
					buy_ref_q  <= cash_q[TICK_W-1] ||
						(CMP_W'(cashx_q) <= CMP_W'(need_q));
					sell_ref_q <= !allow_short_q && (pos_q[TICK_W-1] ||
						(unsigned'(pos_q) < TICK_W'(order_size_q)));
					which_q    <= 1'b0;
					if (ordered_q) begin
						pend_q  <= '{status: ST_ORDERED, order_price: '0, order_volume: '0};
						state_q <= S_OUT;
					end else if (cnt_inc < sw_eff || cnt_inc < lw_eff ||
							order_size_q == '0) begin
						pend_q  <= '{status: ST_NONE, order_price: '0, order_volume: '0};
						state_q <= S_OUT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(which_q ? lsum_q : ssum_q) * PROD_W'(AVG_UNITS);
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						if (!which_q) begin
							qs_q    <= div_quot;
							which_q <= 1'b1;
							state_q <= S_MUL;
						end else begin
							state_q <= S_OUT;
							if (qs_q >= div_quot) begin
								if (buy_ref_q) begin
									pend_q <= '{status: ST_CASH_LIMIT, order_price: '0,
										order_volume: '0};
								end else begin
									pend_q    <= '{status: ST_BUY, order_price: ask_q,
										order_volume: order_size_q};
									ordered_q <= 1'b1;
								end
							end else begin
								if (sell_ref_q) begin
									pend_q <= '{status: ST_SHORT_LIMIT, order_price: '0,
										order_volume: '0};
								end else begin
									pend_q    <= '{status: ST_SELL, order_price: bid_q,
										order_volume: order_size_q};
									ordered_q <= 1'b1;
								end
							end
						end
					end
				end
				S_OUT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				S_SW_INIT: begin
					ssum_q     <= '0;
					lsum_q     <= '0;
					swp_ns_q   <= ns_now;
					swp_nl_q   <= nl_now;
					swp_n_q    <= (ns_now > nl_now) ? ns_now : nl_now;
					swp_k_q    <= '0;
					swp_addr_q <= ptr_dec;
					swp_rv_s1  <= 1'b0;
					state_q    <= S_SW_RUN;
				end
				S_SW_RUN: begin
					if (swp_rv_s1) begin
						if (swp_k_s1 < swp_ns_q) begin
							ssum_q <= ssum_q + SUM_W'(ram_rdata);
						end
						if (swp_k_s1 < swp_nl_q) begin
							lsum_q <= lsum_q + SUM_W'(ram_rdata);
						end
					end
					if (swp_k_q < swp_n_q) begin
						swp_rv_s1  <= 1'b1;
						swp_k_s1   <= swp_k_q;
						swp_k_q    <= swp_k_q + 1'b1;
						swp_addr_q <= swp_addr_dec;
					end else begin
						swp_rv_s1 <= 1'b0;
						if (!swp_rv_s1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
			res_q       <= pend_q;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

[hdl/mcos_chk.sv]
// ----------------------------------------------------------------------------
// mcos_chk
// Port-level checks for the crossover order signal block, bound to its top.
// ----------------------------------------------------------------------------
`include "ma_crossover_order_signal_assert.svh"

module mcos_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                evt_valid,
	input logic                evt_ready,
	input logic                res_valid,
	input logic                res_ready,
	input mcos_pkg::mcos_out_t res
);

	import mcos_pkg::*;

	// A result beat that is not taken stays on the port unchanged.
	`MCOS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result beat changed while stalled")

	// Only buys and sells carry a price and a volume.
	`MCOS_ASSERT_NOW(a_no_trade_zero, res_valid && res.status != ST_BUY && res.status != ST_SELL, res.order_price == '0 && res.order_volume == '0, "non-trade result carries price or volume")

	`MCOS_ASSERT_NOW(a_trade_nonzero, res_valid && (res.status == ST_BUY || res.status == ST_SELL), res.order_price != '0 && res.order_volume != '0, "trade result without price or volume")

	// The block works on one input beat at a time.
	`MCOS_ASSERT_NEXT(a_one_in_flight, evt_valid && evt_ready, !evt_ready, "input taken while a beat is in flight")

endmodule

bind ma_crossover_order_signal mcos_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
